>>> rtl/sqf_pkg.sv
// Shared types, constants and arithmetic helpers for the Q8 shape-function unit.
package sqf_pkg;

  localparam int FRAC_BITS = 14;
  localparam int CW        = 16;   // coordinate and result width
  localparam int OPW       = 17;   // multiplier operand width
  localparam int PW        = 34;   // first-stage product width
  localparam int AW        = 18;   // rounded first factor of the shape value
  localparam int PPW       = 36;   // second-stage product width

  localparam int MQ_DEPTH  = 2;    // point queue between front and back
  localparam int OQ_DEPTH  = 8;    // result queue
  localparam int OQ_AW     = 3;
  localparam int OQ_CW     = 4;

  localparam logic [2:0] LAST_NODE = 3'd7;

  localparam logic signed [CW-1:0]  ONE_C  = CW'(longint'(1) << FRAC_BITS);
  localparam logic signed [OPW-1:0] ONE_OP = OPW'(longint'(1) << FRAC_BITS);
  localparam logic signed [PW-1:0]  ONE_SQ = PW'(longint'(1) << (2 * FRAC_BITS));

  // Nodes with a negative xi / eta sign: corners 0,3 and midside 7 for xi;
  // corners 0,1 and midside 4 for eta.
  localparam logic [7:0] SX_NEG = 8'b1000_1001;
  localparam logic [7:0] SY_NEG = 8'b0001_0011;

  typedef enum logic [1:0] {
    NODE_CORNER,
    NODE_MID_X,    // midside on the xi = 0 line
    NODE_MID_Y     // midside on the eta = 0 line
  } node_kind_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 err;
  } point_t;

  typedef struct packed {
    logic [2:0]           node;
    logic signed [CW-1:0] dxi;
    logic signed [CW-1:0] deta;
    logic signed [CW-1:0] val;
    logic                 last;
    logic                 err;
  } res_t;

  function automatic node_kind_t node_kind(input logic [2:0] k);
    node_kind_t r;
    case (k)
      3'd4, 3'd6: r = NODE_MID_X;
      3'd5, 3'd7: r = NODE_MID_Y;
      default:    r = NODE_CORNER;
    endcase
    return r;
  endfunction

  // Round to nearest, ties toward +inf.
  function automatic logic signed [PPW-1:0] rnd(input logic signed [PPW-1:0] v,
                                                input int s);
    logic signed [PPW-1:0] h;
    h = PPW'(longint'(1) << (s - 1));
    return (v + h) >>> s;
  endfunction

  function automatic logic signed [CW-1:0] sat16(input logic signed [PPW-1:0] v);
    logic signed [CW-1:0] r;
    if (v > PPW'(32767)) r = 16'sh7fff;
    else if (v < -PPW'(32768)) r = 16'sh8000;
    else r = v[CW-1:0];
    return r;
  endfunction

endpackage

>>> rtl/serendipity_q8_shape_functions_unit.sv
// Top level of the eight-node serendipity shape-function unit.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------
//   input    | push / full          | in_xi_coord, in_eta_coord
//   result   | empty / pop          | out_node_number, out_deriv_xi,
//            |                      | out_deriv_eta, out_shape_value,
//            |                      | out_last_node, out_range_error
//
// Each point yields eight items, one node per cycle while the result queue has
// room; that rate is set by the back part, which issues one node into its
// pipeline per cycle unless it stalls for room. A point's first item passes
// the point queue, the pipeline stages and the result queue to the ports.
// Reset (rst_n low, synchronous) empties both queues and the pipeline.
// With pop low, the result queue fills, the back part stops issuing, the point
// queue fills and full rises; no item is dropped.
module serendipity_q8_shape_functions_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] in_xi_coord,
  input  logic signed [15:0] in_eta_coord,
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         out_node_number,
  output logic signed [15:0] out_deriv_xi,
  output logic signed [15:0] out_deriv_eta,
  output logic signed [15:0] out_shape_value,
  output logic               out_last_node,
  output logic               out_range_error
);
  import sqf_pkg::*;

  logic             q_valid, q_pop, res_wr;
  point_t           q_point;
  res_t             res, head;
  logic [OQ_CW-1:0] oq_cnt;

  sqf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .xi_coord  (in_xi_coord),
    .eta_coord (in_eta_coord),
    .q_valid   (q_valid),
    .q_point   (q_point),
    .q_pop     (q_pop)
  );

  sqf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_point (q_point),
    .q_pop   (q_pop),
    .oq_cnt  (oq_cnt),
    .res_wr  (res_wr),
    .res     (res)
  );

  sqf_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (res_wr),
    .wr_data (res),
    .pop     (pop),
    .empty   (empty),
    .rd_data (head),
    .cnt     (oq_cnt)
  );

  assign out_node_number = head.node;
  assign out_deriv_xi    = head.dxi;
  assign out_deriv_eta   = head.deta;
  assign out_shape_value = head.val;
  assign out_last_node   = head.last;
  assign out_range_error = head.err;

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_wr |-> (oq_cnt < OQ_CW'(OQ_DEPTH)))
    else $error("result queue written while full");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("point queue popped while empty");

  a_last_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (res_wr && res.last) |-> (res.node == LAST_NODE))
    else $error("last flag on a node other than the eighth");
`endif

endmodule

>>> rtl/sqf_front.sv
// Front part: input accept, coordinate saturation and the point queue.
module sqf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  logic signed [15:0]  xi_coord,
  input  logic signed [15:0]  eta_coord,
  output logic                q_valid,
  output sqf_pkg::point_t     q_point,
  input  logic                q_pop
);
  import sqf_pkg::*;

  point_t     mem_r [MQ_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_en;
  point_t     pt;

  // Clamp each coordinate to [-1, 1] and flag it.
  always_comb begin
    pt.err = 1'b0;
    pt.x   = xi_coord;
    pt.y   = eta_coord;
    if (xi_coord > ONE_C) begin
      pt.x   = ONE_C;
      pt.err = 1'b1;
    end else if (xi_coord < -ONE_C) begin
      pt.x   = -ONE_C;
      pt.err = 1'b1;
    end
    if (eta_coord > ONE_C) begin
      pt.y   = ONE_C;
      pt.err = 1'b1;
    end else if (eta_coord < -ONE_C) begin
      pt.y   = -ONE_C;
      pt.err = 1'b1;
    end
  end

  assign full    = (cnt_r == 2'(MQ_DEPTH));
  assign wr_en   = push && !full;
  assign q_valid = (cnt_r != 2'd0);
  assign q_point = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en && !q_pop) cnt_nxt = cnt_r + 2'd1;
    else if (!wr_en && q_pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_ptr_r] <= pt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> rtl/sqf_back.sv
// Back part: node sequencer and the three-stage multiply pipeline.
module sqf_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  sqf_pkg::point_t               q_point,
  output logic                          q_pop,
  input  logic [sqf_pkg::OQ_CW-1:0]     oq_cnt,
  output logic                          res_wr,
  output sqf_pkg::res_t                 res
);
  import sqf_pkg::*;

  logic [2:0]             node_r, node_nxt;
  logic                   issue;
  logic [OQ_CW:0]         pending;
  node_kind_t             kind;
  logic                   sxn, syn;
  logic signed [OPW-1:0]  x, y, ax, ay, sxx, syy;
  logic signed [OPW-1:0]  a1, b1, a2, b2, a3, b3, bop;

  // stage 1
  logic                   s1_v_r;
  node_kind_t             s1_kind_r;
  logic                   s1_sxn_r, s1_syn_r, s1_err_r;
  logic [2:0]             s1_node_r;
  logic signed [PW-1:0]   s1_m1_r, s1_m2_r, s1_m3_r;
  logic signed [OPW-1:0]  s1_b_r;

  // stage 2
  logic signed [PW-1:0]   q;
  logic signed [PPW-1:0]  qe, qs_x, qs_y;
  logic signed [PPW-1:0]  dxi_w, deta_w;
  logic                   s2_v_r, s2_corner_r, s2_err_r;
  logic [2:0]             s2_node_r;
  logic signed [AW-1:0]   s2_a_r;
  logic signed [OPW-1:0]  s2_b_r;
  logic signed [CW-1:0]   s2_dxi_r, s2_deta_r;

  // stage 3
  logic                   s3_v_r, s3_corner_r, s3_err_r;
  logic [2:0]             s3_node_r;
  logic signed [PPW-1:0]  s3_p_r;
  logic signed [CW-1:0]   s3_dxi_r, s3_deta_r;

  // Issue only while the result queue has room for everything in flight.
  assign pending = (OQ_CW+1)'(oq_cnt) + (OQ_CW+1)'(s1_v_r)
                 + (OQ_CW+1)'(s2_v_r) + (OQ_CW+1)'(s3_v_r);
  assign issue    = q_valid && (pending < (OQ_CW+1)'(OQ_DEPTH));
  assign q_pop    = issue && (node_r == LAST_NODE);
  assign node_nxt = issue ? node_r + 3'd1 : node_r;

  // Select multiplier operands for the current node.
  always_comb begin
    kind = node_kind(node_r);
    sxn  = SX_NEG[node_r];
    syn  = SY_NEG[node_r];
    x    = OPW'(q_point.x);
    y    = OPW'(q_point.y);
    sxx  = sxn ? -x : x;
    syy  = syn ? -y : y;
    ax   = ONE_OP + sxx;
    ay   = ONE_OP + syy;
    case (kind)
      NODE_CORNER: begin
        a1  = ax;
        b1  = ay;
        a2  = ay;
        b2  = (sxn ^ syn) ? (x <<< 1) - y : (x <<< 1) + y;
        a3  = ax;
        b3  = (sxn ^ syn) ? (y <<< 1) - x : (y <<< 1) + x;
        bop = sxx + syy - ONE_OP;
      end
      NODE_MID_X: begin
        a1  = x;
        b1  = x;
        a2  = -x;
        b2  = ay;
        a3  = '0;
        b3  = '0;
        bop = ay;
      end
      NODE_MID_Y: begin
        a1  = y;
        b1  = y;
        a2  = '0;
        b2  = '0;
        a3  = -y;
        b3  = ax;
        bop = ax;
      end
      default: begin
        a1  = '0;
        b1  = '0;
        a2  = '0;
        b2  = '0;
        a3  = '0;
        b3  = '0;
        bop = '0;
      end
    endcase
  end

  // Stage 2: form 1 - c^2 for midsides, round, derive both derivatives.
  always_comb begin
    q    = (s1_kind_r == NODE_CORNER) ? s1_m1_r : ONE_SQ - s1_m1_r;
    qe   = PPW'(q);
    qs_x = s1_sxn_r ? -qe : qe;
    qs_y = s1_syn_r ? -qe : qe;
    case (s1_kind_r)
      NODE_CORNER: begin
        dxi_w  = rnd(PPW'(s1_m2_r), FRAC_BITS + 2);
        deta_w = rnd(PPW'(s1_m3_r), FRAC_BITS + 2);
      end
      NODE_MID_X: begin
        dxi_w  = rnd(PPW'(s1_m2_r), FRAC_BITS);
        deta_w = rnd(qs_y, FRAC_BITS + 1);
      end
      NODE_MID_Y: begin
        dxi_w  = rnd(qs_x, FRAC_BITS + 1);
        deta_w = rnd(PPW'(s1_m3_r), FRAC_BITS);
      end
      default: begin
        dxi_w  = '0;
        deta_w = '0;
      end
    endcase
  end

  assign res_wr    = s3_v_r;
  assign res.node  = s3_node_r;
  assign res.dxi   = s3_dxi_r;
  assign res.deta  = s3_deta_r;
  assign res.val   = sat16(rnd(s3_p_r, s3_corner_r ? FRAC_BITS + 2 : FRAC_BITS + 1));
  assign res.last  = (s3_node_r == LAST_NODE);
  assign res.err   = s3_err_r;

  always_ff @(posedge clk) begin
    s1_kind_r   <= kind;
    s1_sxn_r    <= sxn;
    s1_syn_r    <= syn;
    s1_err_r    <= q_point.err;
    s1_node_r   <= node_r;
    s1_m1_r     <= a1 * b1;
    s1_m2_r     <= a2 * b2;
    s1_m3_r     <= a3 * b3;
    s1_b_r      <= bop;

    s2_corner_r <= (s1_kind_r == NODE_CORNER);
    s2_err_r    <= s1_err_r;
    s2_node_r   <= s1_node_r;
    s2_a_r      <= AW'(rnd(qe, FRAC_BITS));
    s2_b_r      <= s1_b_r;
    s2_dxi_r    <= sat16(dxi_w);
    s2_deta_r   <= sat16(deta_w);

    s3_corner_r <= s2_corner_r;
    s3_err_r    <= s2_err_r;
    s3_node_r   <= s2_node_r;
    s3_p_r      <= PPW'(s2_a_r * s2_b_r);
    s3_dxi_r    <= s2_dxi_r;
    s3_deta_r   <= s2_deta_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_r <= 3'd0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      node_r <= node_nxt;
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

endmodule

>>> rtl/sqf_outq.sv
// Result queue holding finished node items until they are popped.
module sqf_outq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr,
  input  sqf_pkg::res_t              wr_data,
  input  logic                       pop,
  output logic                       empty,
  output sqf_pkg::res_t              rd_data,
  output logic [sqf_pkg::OQ_CW-1:0]  cnt
);
  import sqf_pkg::*;

  res_t             mem_r [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [OQ_CW-1:0] cnt_r, cnt_nxt;
  logic             rd;

  assign empty   = (cnt_r == '0);
  assign rd      = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];
  assign cnt     = cnt_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr && !rd) cnt_nxt = cnt_r + 1'b1;
    else if (!wr && rd) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (rd) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
